@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define AST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define AST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// Types, widths and codes of the autopilot steer and throttle step unit.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Defaults of the top-level parameters (centidegrees)
    localparam int MAX_STEER_DEF = 3000;
    localparam int STEER_TOL_DEF = 100;

    // Field widths
    localparam int DIST_W  = 24;
    localparam int ANGLE_W = 16;
    localparam int RAD_W   = 16;
    localparam int PCT_W   = 7;
    localparam int GAIN_W  = 12;
    localparam int THR_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = CFG_IDX_W'(7);

    // Heading error arithmetic: a raw bearing difference spans +-65535
    localparam int ERR_W      = 18;
    localparam int WRAP_HALF  = 18000;
    localparam int WRAP_FULL  = 36000;
    localparam int GAIN_SHIFT = 8;

    // Taper product and its divider
    localparam int TAPER_W   = PCT_W + RAD_W;
    localparam int DIV_STEPS = TAPER_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_CCW  = 2'd1,
        MOTOR_CW   = 2'd2
    } motor_t;

    typedef struct packed {
        logic                      navigate;
        logic [DIST_W-1:0]         distance;
        logic [ANGLE_W-1:0]        nav_bearing;
        logic [ANGLE_W-1:0]        heading;
        logic signed [ANGLE_W-1:0] steer_angle;
        logic                      steer_valid;
        logic                      halt;
        logic                      lock_enable;
        logic [ANGLE_W-1:0]        lock_bearing;
        logic                      direct_request;
        logic signed [ANGLE_W-1:0] direct_angle;
        logic signed [THR_W-1:0]   manual_throttle;
    } ast_in_t;

    typedef struct packed {
        logic signed [THR_W-1:0] throttle_percent;
        motor_t                  motor_drive;
        logic                    holding;
        logic                    steer_fault;
    } ast_out_t;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load;
        logic wrap;
        logic mul;
        logic clamp;
        logic div_step;
        logic finish;
    } ast_cmd_t;

endpackage

@@ design/ast_in_if.sv @@
// ----------------------------------------------------------------------------
// ast_in_if
// Valid/ready channel carrying one control tick sample.
// ----------------------------------------------------------------------------
interface ast_in_if;
    import ast_pkg::*;

    logic    valid;
    logic    ready;
    ast_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/ast_out_if.sv @@
// ----------------------------------------------------------------------------
// ast_out_if
// Valid/ready channel carrying one throttle and motor command.
// ----------------------------------------------------------------------------
interface ast_out_if;
    import ast_pkg::*;

    logic     valid;
    logic     ready;
    ast_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/ast_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ast_cfg_if
// Valid/ready register write channel.
// ----------------------------------------------------------------------------
interface ast_cfg_if;
    import ast_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ design/ast_ctrl.sv @@
// ----------------------------------------------------------------------------
// ast_ctrl
// Sequencer of the step unit: walks one sample through the datapath and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module ast_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ast_pkg::ast_cmd_t cmd
);
    import ast_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP0,
        ST_WRAP1,
        ST_MUL,
        ST_CLAMP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 take;
    logic                 emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    // Finish only into a free (or draining) output register
    assign emit      = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = take;
        cmd.wrap     = (state_reg == ST_WRAP0) || (state_reg == ST_WRAP1);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.clamp    = (state_reg == ST_CLAMP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.finish   = emit;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_WRAP0;
                end
            end
            ST_WRAP0: state_next = ST_WRAP1;
            ST_WRAP1: state_next = ST_MUL;
            ST_MUL:   state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                state_next = ST_DIV;
                cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/ast_dp.sv @@
// ----------------------------------------------------------------------------
// ast_dp
// Datapath of the step unit: registers, hold flag, heading error wrap,
// gain multiply and clamp, taper multiply and restoring divider, and the
// result register.
// ----------------------------------------------------------------------------
module ast_dp #(
    parameter int MaxSteer = ast_pkg::MAX_STEER_DEF,
    parameter int SteerTol = ast_pkg::STEER_TOL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ast_pkg::ast_cmd_t               cmd,
    input  ast_pkg::ast_in_t                in_data,
    input  logic                            cfg_we,
    input  logic [ast_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ast_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ast_pkg::ast_out_t               res_data
);
    import ast_pkg::*;

    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int TGT_W  = PROD_W - GAIN_SHIFT;
    localparam int MERR_W = ANGLE_W + 1;
    localparam int THR_X  = THR_W + 2;

    localparam logic signed [ERR_W-1:0]  HALF_P   = ERR_W'(WRAP_HALF);
    localparam logic signed [ERR_W-1:0]  HALF_N   = ERR_W'(-WRAP_HALF);
    localparam logic signed [ERR_W-1:0]  FULL     = ERR_W'(WRAP_FULL);
    localparam logic signed [TGT_W-1:0]  STEER_P  = TGT_W'(MaxSteer);
    localparam logic signed [TGT_W-1:0]  STEER_N  = TGT_W'(-MaxSteer);
    localparam logic signed [MERR_W-1:0] TOL_P    = MERR_W'(SteerTol);
    localparam logic signed [MERR_W-1:0] TOL_N    = MERR_W'(-SteerTol);
    localparam logic signed [THR_X-1:0]  THR_MAX  = THR_X'(100);
    localparam logic signed [THR_X-1:0]  THR_MIN  = THR_X'(-100);

    // Configuration registers
    logic [RAD_W-1:0]  arrival_reg;
    logic [RAD_W-1:0]  leave_reg;
    logic [RAD_W-1:0]  deadband_reg;
    logic [RAD_W-1:0]  slowdown_reg;
    logic [PCT_W-1:0]  cruise_reg;
    logic [PCT_W-1:0]  approach_reg;
    logic [PCT_W-1:0]  hold_thr_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Working registers
    ast_in_t                   in_reg;
    logic                      hold_reg;
    logic                      hold_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [PROD_W-1:0]  sprod_reg;
    logic [TAPER_W-1:0]        tprod_reg;
    motor_t                    motor_reg;
    motor_t                    motor_next;
    logic [RAD_W-1:0]          rem_reg;
    logic [TAPER_W-1:0]        quo_reg;
    ast_out_t                  res_reg;
    ast_out_t                  res_next;

    logic [ANGLE_W-1:0]        bearing;
    logic signed [PCT_W+1:0]   span;
    logic [PCT_W-1:0]          span_mag;
    logic signed [TGT_W-1:0]   tgt_raw;
    logic signed [ANGLE_W-1:0] tgt;
    logic signed [ANGLE_W-1:0] aim;
    logic signed [MERR_W-1:0]  merr;
    logic [RAD_W:0]            shifted;
    logic [RAD_W:0]            trial;
    logic signed [THR_X-1:0]   q_ext;
    logic signed [THR_X-1:0]   taper;
    logic signed [THR_X-1:0]   thr_raw;
    logic signed [THR_X-1:0]   thr_sat;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_reg  <= RAD_W'(50);
            leave_reg    <= RAD_W'(100);
            deadband_reg <= RAD_W'(30);
            slowdown_reg <= RAD_W'(300);
            cruise_reg   <= PCT_W'(50);
            approach_reg <= PCT_W'(20);
            hold_thr_reg <= PCT_W'(15);
            gain_reg     <= GAIN_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ARRIVAL:  arrival_reg  <= cfg_wdata[RAD_W-1:0];
                REG_LEAVE:    leave_reg    <= cfg_wdata[RAD_W-1:0];
                REG_DEADBAND: deadband_reg <= cfg_wdata[RAD_W-1:0];
                REG_SLOWDOWN: slowdown_reg <= cfg_wdata[RAD_W-1:0];
                REG_CRUISE:   cruise_reg   <= cfg_wdata[PCT_W-1:0];
                REG_APPROACH: approach_reg <= cfg_wdata[PCT_W-1:0];
                REG_HOLD_THR: hold_thr_reg <= cfg_wdata[PCT_W-1:0];
                REG_GAIN:     gain_reg     <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold hysteresis, evaluated on the incoming sample
    always_comb
    begin
        if (!in_data.navigate)
        begin
            hold_next = 1'b0;
        end
        else if (!hold_reg && (in_data.distance <= DIST_W'(arrival_reg)))
        begin
            hold_next = 1'b1;
        end
        else if (hold_reg && (in_data.distance > DIST_W'(leave_reg)))
        begin
            hold_next = 1'b0;
        end
        else
        begin
            hold_next = hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hold_reg <= hold_next;
        end
    end

    // Heading error: raw difference, then one wrap correction per step
    assign bearing = in_data.navigate ? in_data.nav_bearing : in_data.lock_bearing;

    always_comb
    begin
        if (cmd.load)
        begin
            err_next = $signed({2'b00, bearing}) - $signed({2'b00, in_data.heading});
        end
        else if (err_reg >= HALF_P)
        begin
            err_next = err_reg - FULL;
        end
        else if (err_reg < HALF_N)
        begin
            err_next = err_reg + FULL;
        end
        else
        begin
            err_next = err_reg;
        end
    end

    // Taper span magnitude
    assign span     = $signed({2'b00, cruise_reg}) - $signed({2'b00, approach_reg});
    assign span_mag = span[PCT_W+1] ? PCT_W'(-span) : span[PCT_W-1:0];

    // Gain target: floor shift, then clamp
    always_comb
    begin
        tgt_raw = sprod_reg[PROD_W-1:GAIN_SHIFT];
        if (tgt_raw > STEER_P)
        begin
            tgt = STEER_P[ANGLE_W-1:0];
        end
        else if (tgt_raw < STEER_N)
        begin
            tgt = STEER_N[ANGLE_W-1:0];
        end
        else
        begin
            tgt = tgt_raw[ANGLE_W-1:0];
        end
    end

    // Motor command from the angle error and its deadband
    always_comb
    begin
        aim  = (in_reg.navigate || in_reg.lock_enable) ? tgt : in_reg.direct_angle;
        merr = $signed({aim[ANGLE_W-1], aim})
             - $signed({in_reg.steer_angle[ANGLE_W-1], in_reg.steer_angle});
        motor_next = MOTOR_STOP;
        if (in_reg.steer_valid && !in_reg.halt
            && (in_reg.navigate || in_reg.lock_enable || in_reg.direct_request))
        begin
            if (merr > TOL_P)
            begin
                motor_next = MOTOR_CCW;
            end
            else if (merr < TOL_N)
            begin
                motor_next = MOTOR_CW;
            end
        end
    end

    // Restoring divider step
    assign shifted = {rem_reg, quo_reg[TAPER_W-1]};
    assign trial   = shifted - {1'b0, slowdown_reg};

    // Throttle selection and saturation
    always_comb
    begin
        q_ext = $signed({3'b000, quo_reg[PCT_W-1:0]});
        taper = $signed({3'b000, approach_reg}) + (span[PCT_W+1] ? -q_ext : q_ext);
        if (in_reg.halt)
        begin
            thr_raw = '0;
        end
        else if (in_reg.navigate)
        begin
            if (hold_reg)
            begin
                thr_raw = (in_reg.distance > DIST_W'(deadband_reg))
                        ? $signed({3'b000, hold_thr_reg}) : '0;
            end
            else if (in_reg.distance < DIST_W'(slowdown_reg))
            begin
                thr_raw = taper;
            end
            else
            begin
                thr_raw = $signed({3'b000, cruise_reg});
            end
        end
        else
        begin
            thr_raw = THR_X'(in_reg.manual_throttle);
        end

        if (thr_raw > THR_MAX)
        begin
            thr_sat = THR_MAX;
        end
        else if (thr_raw < THR_MIN)
        begin
            thr_sat = THR_MIN;
        end
        else
        begin
            thr_sat = thr_raw;
        end

        res_next.throttle_percent = thr_sat[THR_W-1:0];
        res_next.motor_drive      = motor_reg;
        res_next.holding          = hold_reg;
        res_next.steer_fault      = !in_reg.steer_valid;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.load || cmd.wrap)
        begin
            err_reg <= err_next;
        end
        if (cmd.mul)
        begin
            sprod_reg <= err_reg * $signed({1'b0, gain_reg});
            tprod_reg <= span_mag * in_reg.distance[RAD_W-1:0];
        end
        if (cmd.clamp)
        begin
            motor_reg <= motor_next;
            rem_reg   <= '0;
            quo_reg   <= tprod_reg;
        end
        if (cmd.div_step)
        begin
            if (!trial[RAD_W])
            begin
                rem_reg <= trial[RAD_W-1:0];
                quo_reg <= {quo_reg[TAPER_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[RAD_W-1:0];
                quo_reg <= {quo_reg[TAPER_W-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

endmodule

@@ design/autopilot_steer_throttle_step_unit.sv @@
// ----------------------------------------------------------------------------
// autopilot_steer_throttle_step_unit
// One control tick of a boat autopilot: waypoint hold hysteresis, throttle
// taper and steering motor command.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Transaction
//  -------   ---------  -------------  ------------------------------------
//  tick      in         valid/ready    one control tick sample
//  result    out        valid/ready    throttle, motor, hold, sensor fault
//  cfg       in         valid/ready    register write (index, wdata)
//
//  From acceptance to a loaded result a sample passes through two wrap steps,
//  one multiply, one clamp, 23 restoring divider steps and a finish step.
//  The taper divider accounts for most of these steps.
//  One sample is in work at a time; tick reopens once the result is loaded.
//  A stalled result holds the finish cycle until the output register frees.
//  Reset (async, active low) restores register defaults and clears the hold flag.
//
module autopilot_steer_throttle_step_unit #(
    parameter int MaxSteer = ast_pkg::MAX_STEER_DEF,
    parameter int SteerTol = ast_pkg::STEER_TOL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ast_in_if.sink      tick,
    ast_out_if.source   result,
    ast_cfg_if.sink     cfg
);
    import ast_pkg::*;

    ast_cmd_t cmd;
    logic     cfg_we;

    // The user writes only while idle; not enforced here, so always take them
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // Sequencer: handshakes and the command for each datapath step
    ast_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Datapath: capture the sample on load, drive the result register
    ast_dp #(
        .MaxSteer (MaxSteer),
        .SteerTol (SteerTol)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (tick.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_wdata (cfg.wdata),
        .res_data  (result.data)
    );

endmodule

@@ design/ast_checker.sv @@
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks of the step unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_checker (
    input logic       clk,
    input logic       rst_n,
    ast_in_if.sink    tick,
    ast_out_if.source result
);
    import ast_pkg::*;

    // A stalled result holds its valid and payload
    `AST_ASSERT(a_result_hold, clk, rst_n, result.valid && !result.ready |=> result.valid && $stable(result.data), "result dropped or changed while stalled")

    // One sample at a time: after a tick transaction the input stays closed through both wrap steps
    `AST_ASSERT(a_tick_busy, clk, rst_n, tick.valid && tick.ready |=> !tick.ready ##1 !tick.ready, "tick reopened too early")

    // Throttle always saturated to the percent range
    `AST_ASSERT(a_thr_range, clk, rst_n, result.valid |-> (result.data.throttle_percent <= 8'sd100) && (result.data.throttle_percent >= -8'sd100), "throttle out of range")

    // Reset empties the output register
    `AST_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !result.valid, "result valid during reset")

endmodule

bind autopilot_steer_throttle_step_unit ast_checker u_ast_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .result (result)
);
